@@ src/mmlf_pkg.sv @@
`timescale 1ns / 1ps

package mmlf_pkg;

    localparam int ModeW  = 3;
    localparam int IdxW   = 5;
    localparam int TimeW  = 10;

    // pattern selectors
    localparam logic [ModeW-1:0] MODE_DARK   = 3'd0;
    localparam logic [ModeW-1:0] MODE_STEADY = 3'd1;
    localparam logic [ModeW-1:0] MODE_TRIPLE = 3'd2;
    localparam logic [ModeW-1:0] MODE_BLINK  = 3'd3;
    localparam logic [ModeW-1:0] MODE_SLOW3  = 3'd4;
    localparam logic [ModeW-1:0] MODE_SOS    = 3'd5;

    // control from the pipeline to the segment timer
    typedef struct packed {
        logic restart;  // config write, back to first segment
        logic step;     // a beat is processed this cycle
        logic tick;     // that beat carries a millisecond tick
    } ctl_t;

    // saved mode plus one, out-of-range sums fall back to steady
    function automatic logic [ModeW-1:0] pick_mode(input logic [7:0] saved);
        logic [7:0] sum;
        sum = saved + 8'd1;
        if (sum > 8'd5) begin
            return MODE_STEADY;
        end
        return sum[ModeW-1:0];
    endfunction

    // number of segments per pattern, zero for unpatterned modes
    function automatic logic [IdxW-1:0] seg_count(input logic [ModeW-1:0] mode);
        case (mode)
            MODE_TRIPLE: return 5'd6;
            MODE_BLINK:  return 5'd2;
            MODE_SLOW3:  return 5'd6;
            MODE_SOS:    return 5'd18;
            default:     return 5'd0;
        endcase
    endfunction

    // segment duration in ms
    function automatic logic [TimeW-1:0] seg_duration(input logic [ModeW-1:0] mode,
                                                      input logic [IdxW-1:0]  idx);
        case (mode)
            MODE_TRIPLE: return (idx == 5'd5) ? 10'd500 : (idx[0] ? 10'd60 : 10'd40);
            MODE_BLINK:  return idx[0] ? 10'd500 : 10'd50;
            MODE_SLOW3:  return idx[0] ? 10'd200 : 10'd100;
            MODE_SOS: begin
                if (idx == 5'd17) begin
                    return 10'd1000;
                end else if (idx >= 5'd6 && idx < 5'd12) begin
                    return 10'd150;
                end
                return 10'd50;
            end
            default:     return 10'd0;
        endcase
    endfunction

endpackage

@@ src/mmlf_seg_timer.sv @@
`timescale 1ns / 1ps

module mmlf_seg_timer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mmlf_pkg::ctl_t        ctl,
    input  logic [2:0]            mode,
    output logic                  led
);
    import mmlf_pkg::*;

    logic [IdxW-1:0]  idx_reg, idx_next;
    logic [TimeW-1:0] time_reg, time_next;
    logic [IdxW-1:0]  len;
    logic [IdxW-1:0]  cur_idx;
    logic [TimeW-1:0] cur_time;
    logic [TimeW:0]   time_inc;
    logic [TimeW-1:0] dur;
    logic             patterned;

    assign len       = seg_count(mode);
    assign patterned = (len != '0);

    // a stray index falls back to the first segment
    assign cur_idx  = (idx_reg >= len) ? '0 : idx_reg;
    assign cur_time = (idx_reg >= len) ? '0 : time_reg;
    assign dur      = seg_duration(mode, cur_idx);
    assign time_inc = {1'b0, cur_time} + {{TimeW{1'b0}}, 1'b1};

    assign led = patterned ? ~cur_idx[0] : (mode == MODE_STEADY);

    always_comb begin
        idx_next  = idx_reg;
        time_next = time_reg;
        if (ctl.restart) begin
            idx_next  = '0;
            time_next = '0;
        end else if (ctl.step) begin
            if (!patterned) begin
                idx_next  = '0;
                time_next = '0;
            end else begin
                idx_next  = cur_idx;
                time_next = cur_time;
                if (ctl.tick) begin
                    if (time_inc >= {1'b0, dur}) begin
                        time_next = '0;
                        idx_next  = (cur_idx + 5'd1 >= len) ? '0 : cur_idx + 5'd1;
                    end else begin
                        time_next = time_inc[TimeW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            time_reg <= '0;
        end else begin
            idx_reg  <= idx_next;
            time_reg <= time_next;
        end
    end

endmodule

@@ src/multi_mode_led_flasher.sv @@
`timescale 1ns / 1ps

// multi-mode led flasher
//
// input stream: one beat per millisecond slot, s_tdata[0] = ms_tick; a tick
// of 1 advances the pattern timer, 0 holds it. every input beat yields one
// output beat carrying the led level for that slot plus the selected mode.
// config: cfg_wen/cfg_wdata write saved_mode (8 bits); the active mode is
// saved_mode + 1 (8-bit wrap), sums above 5 select steady on, 255 gives dark.
// a write also restarts the pattern at its first (lit) segment. write only
// while no beats are in flight.
// path: an accepted beat goes through the input register, then the result
// register, which drives m_tvalid; a low m_tready can hold it in the input
// register. throughput one beat per cycle while the receiver keeps m_tready
// high, with the segment timer updated as each beat moves to the result stage.
// stall: when m_tready is low the result register holds and the input
// register fills; s_tready drops once both are occupied, no beat is lost.
// reset: aresetn (sync, active low) empties both stages, clears saved_mode
// to 0 (mode 1, steady on) and puts the timer on the first segment.
module multi_mode_led_flasher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,       // saved_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,         // [0] ms_tick, [7:1] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata          // [0] led_on, [3:1] active_mode,
                                        // [6:4] mode_to_save, [7] zero
);
    import mmlf_pkg::*;

    logic [7:0]       saved_reg;
    logic             in_valid_reg;
    logic             tick_reg;
    logic             out_valid_reg;
    logic             led_reg;
    logic [ModeW-1:0] mode_reg;
    logic [ModeW-1:0] mode;
    logic             advance;
    logic             led;
    ctl_t             ctl;

    // the result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign mode = pick_mode(saved_reg);

    // restart on a config write, step when a beat moves to the result stage
    assign ctl = '{restart: cfg_wen, step: in_valid_reg && advance, tick: tick_reg};

    mmlf_seg_timer u_timer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .mode    (mode),
        .led     (led)
    );

    // saved mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_reg <= 8'd0;
        end else if (cfg_wen) begin
            saved_reg <= cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            tick_reg <= s_tdata[0];
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            led_reg  <= led;
            mode_reg <= mode;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, mode_reg, mode_reg, led_reg};

endmodule

@@ src/mmlf_checker.sv @@
`timescale 1ns / 1ps

module mmlf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // result register empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    // mode stays in the defined range and is echoed as the save value
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:1] <= 3'd5 && m_tdata[6:4] == m_tdata[3:1]
                     && !m_tdata[7])
        else $error("bad mode field");

    // dark mode never lights, steady mode always lights
    a_fixed_modes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:1] == 3'd0 || m_tdata[3:1] == 3'd1)
            |-> m_tdata[0] == m_tdata[1])
        else $error("led level wrong for unpatterned mode");

endmodule

bind multi_mode_led_flasher mmlf_checker u_mmlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb_multi_mode_led_flasher.sv @@
`timescale 1ns / 1ps

module tb_multi_mode_led_flasher;
    import mmlf_pkg::*;

    localparam int unsigned CycleLimit = 300000;

    // tracks the flasher: saved mode, segment position and the led beats still owed
    class led_flash_board;
        logic [7:0]       saved_mode;
        logic [IdxW-1:0]  seg_idx;
        logic [TimeW-1:0] seg_ms;
        logic [7:0]       owed_beats[$];
        int               mismatches;

        // on/off durations in ms, lit segment first
        int unsigned triple_ms[6] = '{40, 60, 40, 60, 40, 500};
        int unsigned blink_ms[2]  = '{50, 500};
        int unsigned slow3_ms[6]  = '{100, 200, 100, 200, 100, 200};
        int unsigned sos_ms[18]   = '{50, 50, 50, 50, 50, 50,
                                      150, 150, 150, 150, 150, 150,
                                      50, 50, 50, 50, 50, 1000};

        function new();
            saved_mode = 8'd0;
            seg_idx    = '0;
            seg_ms     = '0;
            mismatches = 0;
        endfunction

        // a write restarts the pattern like a fresh power-up
        function void load_saved_mode(logic [7:0] value);
            saved_mode = value;
            seg_idx    = '0;
            seg_ms     = '0;
        endfunction

        function logic [ModeW-1:0] selected_mode();
            logic [7:0] sum;
            sum = saved_mode + 8'd1;
            if (sum > 8'd5) begin
                return MODE_STEADY;
            end
            return sum[ModeW-1:0];
        endfunction

        function int unsigned segments_in(logic [ModeW-1:0] mode);
            case (mode)
                MODE_TRIPLE: return 6;
                MODE_BLINK:  return 2;
                MODE_SLOW3:  return 6;
                MODE_SOS:    return 18;
                default:     return 0;
            endcase
        endfunction

        function int unsigned dwell_ms(logic [ModeW-1:0] mode, logic [IdxW-1:0] idx);
            case (mode)
                MODE_TRIPLE: return triple_ms[idx];
                MODE_BLINK:  return blink_ms[idx];
                MODE_SLOW3:  return slow3_ms[idx];
                MODE_SOS:    return sos_ms[idx];
                default:     return 0;
            endcase
        endfunction

        // one accepted input beat owes one led beat
        function void note_tick(bit tick);
            logic [ModeW-1:0] mode;
            int unsigned      count;
            int unsigned      elapsed;
            bit               led;
            mode  = selected_mode();
            count = segments_in(mode);
            if (count == 0) begin
                led     = (mode == MODE_STEADY);
                seg_idx = '0;
                seg_ms  = '0;
            end else begin
                if (seg_idx >= count) begin
                    seg_idx = '0;
                    seg_ms  = '0;
                end
                led = ~seg_idx[0];
                if (tick) begin
                    elapsed = seg_ms + 1;
                    if (elapsed >= dwell_ms(mode, seg_idx)) begin
                        seg_ms  = '0;
                        seg_idx = (seg_idx + 1 >= count) ? '0 : seg_idx + 1'b1;
                    end else begin
                        seg_ms = elapsed[TimeW-1:0];
                    end
                end
            end
            owed_beats.push_back({1'b0, mode, mode, led});
        endfunction

        function void report(string msg);
            if (mismatches < 10) begin
                $display("[%0t] %s", $time, msg);
            end
            mismatches++;
        endfunction

        function void check_beat(logic [7:0] got);
            logic [7:0] want;
            if (owed_beats.size() == 0) begin
                report($sformatf("led beat with nothing owed: tdata %h", got));
                return;
            end
            want = owed_beats.pop_front();
            if (got[0] !== want[0] || got[3:1] !== want[3:1] || got[6:4] !== want[6:4]) begin
                report($sformatf("led %b/%b mode %0d/%0d save %0d/%0d (exp/act)",
                                 want[0], got[0], want[3:1], got[3:1],
                                 want[6:4], got[6:4]));
            end
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_wen   = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;   // [0] ms_tick, [7:1] zero
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [0] led_on, [3:1] active_mode, [6:4] mode_to_save

    led_flash_board board = new();
    int unsigned    stall_pct = 0;   // receiver stall chance per cycle, percent
    int unsigned    hold_left = 0;   // cycles of forced back-pressure still to go
    int unsigned    cycles    = 0;

    multi_mode_led_flasher uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("multi_mode_led_flasher regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when one is armed
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: config writes and accepted beats, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wen) begin
                board.load_saved_mode(cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                board.note_tick(s_tdata[0]);
            end
            if (m_tvalid && m_tready) begin
                board.check_beat(m_tdata);
            end
        end
    end

    // offer count beats; valid stays high across back-to-back beats
    task automatic send_ticks(int count, int unsigned idle_pct, int unsigned tick_pct);
        int sent;
        bit tick;
        sent = 0;
        while (sent < count) begin
            @(negedge aclk);
            if ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                tick = ($urandom_range(99) < tick_pct);
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, tick};
                @(posedge aclk);
                while (!s_tready) begin
                    @(posedge aclk);
                end
                sent++;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // let every owed beat come out, then write saved_mode while the block is idle
    task automatic drain_and_write(logic [7:0] value);
        while (board.owed_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    logic [7:0] corner_modes[8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd254, 8'd255};

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset mode (steady on) with held and advancing ticks
        send_ticks(2, 0, 0);
        send_ticks(2, 0, 100);
        // every mode, the wrap to dark and the fallback to steady
        foreach (corner_modes[i]) begin
            drain_and_write(corner_modes[i]);
            send_ticks(1, 0, 0);
            send_ticks(1, 0, 100);
        end

        // long runs, mostly ticks so segments roll over
        // sos with no idling on either side
        drain_and_write(8'd4);
        stall_pct = 0;
        send_ticks(180, 0, 95);

        // short blink, sender idle most cycles
        drain_and_write(8'd2);
        send_ticks(140, 87, 95);

        // triple flash, receiver stalling most cycles
        drain_and_write(8'd1);
        stall_pct = 87;
        send_ticks(120, 0, 95);

        // slow triple, both sides idling lightly
        drain_and_write(8'd3);
        stall_pct = 12;
        send_ticks(100, 12, 95);

        // unpatterned settings and random saved values
        drain_and_write(8'd255);
        stall_pct = 50;
        send_ticks(12, 50, 50);
        drain_and_write(8'd5);
        send_ticks(12, 30, 50);
        drain_and_write(8'd254);
        stall_pct = 20;
        send_ticks(12, 20, 50);
        drain_and_write(8'($urandom_range(253, 6)));
        send_ticks(12, 40, 50);
        drain_and_write(8'($urandom));
        stall_pct = 0;
        send_ticks(12, 0, 50);

        // long receiver hold-off while the sender keeps offering; input stalls
        drain_and_write(8'($urandom_range(4, 1)));
        @(posedge aclk);
        hold_left = 300;
        send_ticks(40, 0, 90);

        while (board.owed_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (board.mismatches == 0 && board.owed_beats.size() == 0) begin
            $display("multi_mode_led_flasher regression: pass");
        end else begin
            $display("multi_mode_led_flasher regression: fail");
        end
        $finish;
    end

endmodule
